// ----- src/dlrg_pkg.sv -----
`timescale 1ns / 1ps

package dlrg_pkg;

	// func codes carried in s_tuser
	localparam logic [1:0] FUNC_START = 2'd0;
	localparam logic [1:0] FUNC_TICK  = 2'd1;
	localparam logic [1:0] FUNC_SKIP  = 2'd2;

	// fraction is Q0.16: one quotient bit per step
	localparam int FRAC_BITS = 16;
	localparam int CNT_W     = $clog2(FRAC_BITS + 1);

	typedef struct packed {
		logic               go;
		logic [30:0]        num;
		logic signed [31:0] den;
		logic signed [16:0] delta;
		logic [15:0]        end_val;
	} frac_req_t;

	typedef struct packed {
		logic        done;
		logic [15:0] value;
	} frac_rsp_t;

endpackage

// ----- src/dlrg_frac_mac.sv -----
`timescale 1ns / 1ps

module dlrg_frac_mac import dlrg_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  frac_req_t req,
	output frac_rsp_t rsp
);

	logic               busy_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [31:0]        rem_q;
	logic [31:0]        den_q;
	logic signed [16:0] delta_q;
	logic [15:0]        end_q;
	logic signed [32:0] acc_q;

	logic        den_pos;
	logic        num_ge;
	logic [31:0] rem2;
	logic        ge;
	logic [32:0] delta_ext;
	logic [16:0] hi;
	logic [16:0] hi_t;

	assign den_pos   = !req.den[31] && (req.den != 32'sd0);
	assign num_ge    = {1'b0, req.num} >= req.den;
	// remainder stays below den < 2^31, so the shifted-out bit is always zero
	assign rem2      = {rem_q[30:0], 1'b0};
	assign ge        = rem2 >= den_q;
	assign delta_ext = {{16{delta_q[16]}}, delta_q};

	// divide by 2^16 toward zero, then add onto the end value
	assign hi   = acc_q[32:16];
	assign hi_t = hi + {16'd0, acc_q[32] && (acc_q[15:0] != 16'd0)};

	assign rsp.done  = busy_q && (cnt_q == '0);
	assign rsp.value = end_q + hi_t[15:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			cnt_q   <= '0;
			den_q   <= '0;
			delta_q <= '0;
			end_q   <= '0;
			rem_q   <= '0;
			acc_q   <= '0;
		end else if (req.go) begin
			busy_q  <= 1'b1;
			den_q   <= req.den;
			delta_q <= req.delta;
			end_q   <= req.end_val;
			rem_q   <= {1'b0, req.num};
			if (!den_pos) begin
				acc_q <= '0;
				cnt_q <= '0;
			end else if (num_ge) begin
				// fraction clamps to one: the product is delta itself
				acc_q <= {req.delta, 16'd0};
				cnt_q <= '0;
			end else begin
				acc_q <= '0;
				cnt_q <= CNT_W'(FRAC_BITS);
			end
		end else if (busy_q) begin
			if (cnt_q != '0) begin
				// quotient bit MSB first feeds the Horner-style multiply
				rem_q <= ge ? rem2 - den_q : rem2;
				acc_q <= $signed({acc_q[31:0], 1'b0}) + (ge ? $signed(delta_ext) : 33'sd0);
				cnt_q <= cnt_q - CNT_W'(1);
			end else begin
				busy_q <= 1'b0;
			end
		end
	end

`ifndef SYNTH
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		req.go |-> !busy_q) else $error("fraction unit restarted while busy");
	a_done_clears: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |=> !busy_q) else $error("fraction unit stays busy after done");
	a_steps_continue: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && cnt_q != '0) |=> busy_q) else $error("fraction unit quit early");
`endif

endmodule

// ----- src/delayed_linear_ramp_generator.sv -----
`timescale 1ns / 1ps

// Delayed linear ramp generator: s_tuser selects start (0), tick (1) or skip (2); every item
// gives exactly one result item on m_tdata with the current Q8.8 value and status flags.
// A tick that leaves a running ramp with time still remaining goes through the fraction unit,
// which produces one quotient bit of remaining/duration per cycle and folds it into the
// (start - end) product in the same step: 16 steps, then the value is taken into the state,
// the output register is loaded and the result handshake follows. A tick whose remaining
// time is not below the ramp time clamps the fraction to one and skips the steps. All other
// items bypass the fraction unit. The output register lets a new item be accepted while the
// previous result waits for m_tready; a stalled result holds the block before it loads the
// next one.

module delayed_linear_ramp_generator import dlrg_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// [15:0] start_value, [31:16] end_value, [63:32] ramp_time, [95:64] delay_time,
	// [126:96] elapsed, [127] zero
	input  logic [127:0] s_tdata,
	// [1:0] func
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// [15:0] current_value, [16] value_changed, [17] ramp_active, [18] delay_active,
	// [23:19] zero
	output logic [23:0]  m_tdata
);

	typedef enum logic [1:0] {S_IDLE, S_CALC, S_EMIT} state_t;

	state_t             state_q;
	logic [15:0]        value_now_q;
	logic [15:0]        ramp_start_q;
	logic [15:0]        ramp_end_q;
	logic signed [31:0] time_left_q;
	logic signed [31:0] ramp_length_q;
	logic signed [31:0] delay_left_q;
	logic               changed_q;
	logic               m_tvalid_q;
	logic [23:0]        m_tdata_q;

	logic [15:0]        in_start;
	logic [15:0]        in_end;
	logic signed [31:0] in_ramp;
	logic signed [31:0] in_delay;
	logic [30:0]        in_elapsed;
	logic               accept;
	logic               dl_pos;
	logic               tl_pos;
	logic signed [31:0] tl_new;
	logic               tl_new_pos;
	logic               out_free;
	frac_req_t          req;
	frac_rsp_t          rsp;

	assign in_start   = s_tdata[15:0];
	assign in_end     = s_tdata[31:16];
	assign in_ramp    = $signed(s_tdata[63:32]);
	assign in_delay   = $signed(s_tdata[95:64]);
	assign in_elapsed = s_tdata[126:96];

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	assign dl_pos     = !delay_left_q[31] && (delay_left_q != 32'sd0);
	assign tl_pos     = !time_left_q[31] && (time_left_q != 32'sd0);
	assign tl_new     = time_left_q - $signed({1'b0, in_elapsed});
	assign tl_new_pos = !tl_new[31] && (tl_new != 32'sd0);

	always_comb begin
		req.go      = accept && (s_tuser == FUNC_TICK) && !dl_pos && tl_pos && tl_new_pos;
		req.num     = tl_new[30:0];
		req.den     = ramp_length_q;
		req.delta   = $signed({1'b0, ramp_start_q}) - $signed({1'b0, ramp_end_q});
		req.end_val = ramp_end_q;
	end

	dlrg_frac_mac u_frac (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			value_now_q   <= '0;
			ramp_start_q  <= '0;
			ramp_end_q    <= '0;
			time_left_q   <= '0;
			ramp_length_q <= '0;
			delay_left_q  <= '0;
			changed_q     <= 1'b0;
			m_tvalid_q    <= 1'b0;
			m_tdata_q     <= '0;
		end else begin
			// hold a waiting result; drop it once taken
			if (state_q == S_EMIT && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= req.go ? S_CALC : S_EMIT;
						case (s_tuser)
							FUNC_START: begin
								changed_q  <= 1'b1;
								ramp_end_q <= in_end;
								if (in_ramp[31] || in_ramp == 32'sd0) begin
									value_now_q  <= in_end;
									time_left_q  <= '0;
									delay_left_q <= '0;
								end else begin
									delay_left_q  <= in_delay[31] ? 32'sd0 : in_delay;
									ramp_length_q <= in_ramp;
									time_left_q   <= in_ramp;
									ramp_start_q  <= in_start;
									value_now_q   <= in_start;
								end
							end
							FUNC_TICK: begin
								if (dl_pos) begin
									changed_q    <= 1'b0;
									// time past the delay is dropped
									delay_left_q <= delay_left_q - $signed({1'b0, in_elapsed});
								end else if (tl_pos) begin
									changed_q   <= 1'b1;
									time_left_q <= tl_new;
									if (!tl_new_pos) begin
										value_now_q <= ramp_end_q;
									end
								end else begin
									changed_q <= 1'b0;
								end
							end
							FUNC_SKIP: begin
								changed_q <= tl_pos;
								if (tl_pos) begin
									value_now_q <= ramp_end_q;
								end
								time_left_q  <= '0;
								delay_left_q <= '0;
							end
							default: begin
								changed_q <= 1'b0;
							end
						endcase
					end
				end
				S_CALC: begin
					if (rsp.done) begin
						value_now_q <= rsp.value;
						state_q     <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						m_tdata_q <= {5'd0, dl_pos, tl_pos, changed_q, value_now_q};
						state_q   <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTH
	a_done_in_calc: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |-> state_q == S_CALC) else $error("fraction result outside calc state");
	a_go_enters_calc: assert property (@(posedge clk) disable iff (!arst_n)
		req.go |=> state_q == S_CALC) else $error("fraction started without calc state");
	a_emit_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT && out_free) |=> m_tvalid_q) else $error("result item not loaded");
`endif

endmodule

// ----- tb/sv/tb_delayed_linear_ramp_generator.sv -----
`timescale 1ns / 1ps

typedef struct {
	logic [1:0]         func;
	logic [15:0]        start_value;
	logic [15:0]        end_value;
	logic signed [31:0] ramp_time;
	logic signed [31:0] delay_time;
	logic [30:0]        elapsed;
} ramp_cmd_t;

typedef struct {
	logic [15:0] current_value;
	logic        value_changed;
	logic        ramp_active;
	logic        delay_active;
} ramp_status_t;

class ramp_scoreboard;
	logic [15:0]    value_now;
	logic [15:0]    ramp_start;
	logic [15:0]    ramp_end;
	longint         time_left;
	longint         ramp_length;
	longint         delay_left;
	ramp_status_t   status_q[$];
	int             failures;

	function new();
		value_now   = '0;
		ramp_start  = '0;
		ramp_end    = '0;
		time_left   = 0;
		ramp_length = 0;
		delay_left  = 0;
		failures    = 0;
	endfunction

	function int pending();
		return status_q.size();
	endfunction

	// advance the ramp state by one accepted item and queue the status it must report
	function void note_item(ramp_cmd_t cmd);
		ramp_status_t st;
		longint       rt;
		longint       dt;
		longint       el;
		longint       frac;
		longint       delta;
		longint       sum;
		rt = cmd.ramp_time;
		dt = cmd.delay_time;
		el = longint'(cmd.elapsed);
		st.value_changed = 1'b0;
		case (cmd.func)
			dlrg_pkg::FUNC_START: begin
				if (rt <= 0) begin
					value_now  = cmd.end_value;
					ramp_end   = cmd.end_value;
					time_left  = 0;
					delay_left = 0;
				end else begin
					delay_left  = (dt < 0) ? 0 : dt;
					ramp_length = rt;
					time_left   = rt;
					ramp_start  = cmd.start_value;
					ramp_end    = cmd.end_value;
					value_now   = cmd.start_value;
				end
				st.value_changed = 1'b1;
			end
			dlrg_pkg::FUNC_TICK: begin
				if (delay_left > 0) begin
					// time past the end of the delay is dropped
					delay_left = delay_left - el;
				end else if (time_left > 0) begin
					time_left = time_left - el;
					if (time_left <= 0) begin
						value_now = ramp_end;
					end else begin
						frac = 0;
						if (ramp_length > 0) begin
							frac = (time_left * 65536) / ramp_length;
							if (frac > 65536)
								frac = 65536;
						end
						delta = longint'(ramp_start) - longint'(ramp_end);
						sum = longint'(ramp_end) + (delta * frac) / 65536;
						value_now = sum[15:0];
					end
					st.value_changed = 1'b1;
				end
			end
			dlrg_pkg::FUNC_SKIP: begin
				if (time_left > 0) begin
					value_now = ramp_end;
					st.value_changed = 1'b1;
				end
				time_left  = 0;
				delay_left = 0;
			end
			default: ;
		endcase
		st.current_value = value_now;
		st.ramp_active   = (time_left > 0);
		st.delay_active  = (delay_left > 0);
		status_q = {status_q, st};
	endfunction

	function void check_result(logic [23:0] raw);
		ramp_status_t st;
		if (status_q.size() == 0) begin
			failures++;
			if (failures <= 10)
				$display("unexpected result item %h", raw);
			return;
		end
		st = status_q.pop_front();
		if (raw[15:0] !== st.current_value || raw[16] !== st.value_changed ||
		    raw[17] !== st.ramp_active || raw[18] !== st.delay_active) begin
			failures++;
			if (failures <= 10)
				$display({"mismatch: expected value %h chg %b ramp %b delay %b,",
				          " got value %h chg %b ramp %b delay %b"},
				         st.current_value, st.value_changed, st.ramp_active, st.delay_active,
				         raw[15:0], raw[16], raw[17], raw[18]);
		end
	endfunction
endclass

module tb_delayed_linear_ramp_generator;
	import dlrg_pkg::*;

	localparam logic [1:0] FUNC_UNUSED = 2'd3;

	logic         clk = 1'b0;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [127:0] s_tdata;
	logic [1:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [23:0]  m_tdata;

	ramp_scoreboard sb;
	int             items_sent;
	int             burst_left;
	int             results_seen;

	delayed_linear_ramp_generator dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic ramp_cmd_t mk_cmd(logic [1:0] func, logic [15:0] sv, logic [15:0] ev,
	                                     logic signed [31:0] rt, logic signed [31:0] dt,
	                                     logic [30:0] el);
		ramp_cmd_t cmd;
		cmd.func        = func;
		cmd.start_value = sv;
		cmd.end_value   = ev;
		cmd.ramp_time   = rt;
		cmd.delay_time  = dt;
		cmd.elapsed     = el;
		return cmd;
	endfunction

	function automatic ramp_cmd_t rand_cmd(logic [1:0] func);
		return mk_cmd(func, 16'($urandom()), 16'($urandom()), $urandom(), $urandom(),
		              31'($urandom()));
	endfunction

	// offer one item, hold it until accepted, then maybe open a gap before the next burst
	task automatic send_cmd(input ramp_cmd_t cmd);
		int gap;
		s_tuser  <= cmd.func;
		s_tdata  <= {1'b0, cmd.elapsed, cmd.delay_time, cmd.ramp_time,
		             cmd.end_value, cmd.start_value};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		sb.note_item(cmd);
		items_sent++;
		burst_left--;
		if (burst_left <= 0) begin
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = $urandom_range(1, 60);
		end
	endtask

	task automatic send_tick(input logic signed [31:0] rt);
		ramp_cmd_t   cmd;
		logic [30:0] el;
		if (rt > 0 && rt <= 4000 && $urandom_range(0, 9) < 7)
			el = 31'($urandom_range(0, 800));
		else
			el = 31'($urandom() >> (1 + $urandom_range(0, 30)));
		cmd = rand_cmd(FUNC_TICK);
		cmd.elapsed = el;
		send_cmd(cmd);
	endtask

	// one start followed by a run of ticks, with the odd skip or unused code mixed in
	task automatic send_ramp_sequence();
		ramp_cmd_t cmd;
		int        sel;
		int        n_ticks;
		cmd = rand_cmd(FUNC_START);
		sel = $urandom_range(0, 99);
		if (sel < 70)
			cmd.ramp_time = $urandom_range(1, 4000);
		else if (sel < 85)
			cmd.ramp_time = $urandom_range(1, 32'h7FFF_FFFF);
		else if (sel < 95)
			cmd.ramp_time = 32'd0 - $urandom_range(0, 1000);
		else
			cmd.ramp_time = 1;
		sel = $urandom_range(0, 99);
		if (sel < 50)
			cmd.delay_time = 0;
		else if (sel < 70)
			cmd.delay_time = 32'd0 - $urandom_range(1, 32'h7FFF_FFFF);
		else if (sel < 95)
			cmd.delay_time = $urandom_range(1, 3000);
		else
			cmd.delay_time = $urandom_range(1, 32'h7FFF_FFFF);
		send_cmd(cmd);
		n_ticks = $urandom_range(2, 14);
		repeat (n_ticks) begin
			sel = $urandom_range(0, 99);
			if (sel < 8)
				send_cmd(rand_cmd(FUNC_SKIP));
			else if (sel < 12)
				send_cmd(rand_cmd(FUNC_UNUSED));
			else
				send_tick(cmd.ramp_time);
		end
	endtask

	initial begin : result_sink
		int cyc;
		int mode;
		int hold_left;
		bit held;
		cyc       = 0;
		mode      = 0;
		hold_left = 0;
		held      = 1'b0;
		results_seen = 0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready) begin
				sb.check_result(m_tdata);
				results_seen++;
			end
			cyc++;
			if (cyc % 97 == 0)
				mode = $urandom_range(0, 3);
			// one long hold-off so the block backs up into its input
			if (!held && results_seen >= 400) begin
				held      = 1'b1;
				hold_left = 300;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				case (mode)
					0:       m_tready <= 1'b1;
					1:       m_tready <= ($urandom_range(0, 1) == 1);
					2:       m_tready <= ($urandom_range(0, 9) != 0);
					default: m_tready <= (cyc % 4 != 3);
				endcase
			end
		end
	end

	initial begin
		#4_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	initial begin : stimulus
		int wait_cycles;
		sb = new();
		items_sent = 0;
		burst_left = $urandom_range(1, 60);
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= FUNC_START;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// full-scale falling ramp, zero-length tick, landing exactly on the end
		send_cmd(mk_cmd(FUNC_START, 16'hFFFF, 16'h0000, 1000, 0, 0));
		send_cmd(mk_cmd(FUNC_TICK, 0, 0, 0, 0, 1));
		send_cmd(mk_cmd(FUNC_TICK, 0, 0, 0, 0, 250));
		send_cmd(mk_cmd(FUNC_TICK, 0, 0, 0, 0, 0));
		send_cmd(mk_cmd(FUNC_TICK, 0, 0, 0, 0, 749));
		send_cmd(mk_cmd(FUNC_TICK, 0, 0, 0, 0, 10));
		// rising ramp with a negative delay, skip mid-ramp, skip with nothing running
		send_cmd(mk_cmd(FUNC_START, 16'h0000, 16'hFFFF, 7, -5, 0));
		send_cmd(mk_cmd(FUNC_TICK, 0, 0, 0, 0, 3));
		send_cmd(mk_cmd(FUNC_SKIP, 0, 0, 0, 0, 0));
		send_cmd(mk_cmd(FUNC_SKIP, 0, 0, 0, 0, 0));
		// delay counted down, overshoot dropped, then the ramp moves
		send_cmd(mk_cmd(FUNC_START, 16'h1234, 16'hABCD, 100, 50, 0));
		send_cmd(mk_cmd(FUNC_TICK, 0, 0, 0, 0, 20));
		send_cmd(mk_cmd(FUNC_TICK, 0, 0, 0, 0, 40));
		send_cmd(mk_cmd(FUNC_TICK, 0, 0, 0, 0, 30));
		// skip while still in the delay
		send_cmd(mk_cmd(FUNC_START, 16'h0005, 16'h0009, 10, 1000, 0));
		send_cmd(mk_cmd(FUNC_SKIP, 0, 0, 0, 0, 0));
		// non-positive durations set the end value at once
		send_cmd(mk_cmd(FUNC_START, 16'h1111, 16'h4242, 0, 77, 0));
		send_cmd(mk_cmd(FUNC_START, 16'h0000, 16'hFFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0));
		send_cmd(rand_cmd(FUNC_UNUSED));
		// longest ramp with the most negative delay and extreme ticks
		send_cmd(mk_cmd(FUNC_START, 16'hFFFF, 16'h0000, 32'h7FFF_FFFF, 32'h8000_0000, 0));
		send_cmd(mk_cmd(FUNC_TICK, 0, 0, 0, 0, 1));
		send_cmd(mk_cmd(FUNC_TICK, 0, 0, 0, 0, 31'h3FFF_FFFF));
		send_cmd(mk_cmd(FUNC_TICK, 0, 0, 0, 0, 31'h7FFF_FFFF));
		send_cmd(mk_cmd(FUNC_START, 16'h8000, 16'h7FFF, 3, 0, 0));
		send_cmd(mk_cmd(FUNC_TICK, 0, 0, 0, 0, 2));
		send_cmd(mk_cmd(FUNC_START, 16'hFFFF, 16'hFFFF, 5, 32'h7FFF_FFFF, 0));
		send_cmd(mk_cmd(FUNC_TICK, 0, 0, 0, 0, 31'h7FFF_FFFF));
		send_cmd(mk_cmd(FUNC_TICK, 0, 0, 0, 0, 5));

		items_sent = 0;
		while (items_sent < 1100) begin
			if ($urandom_range(0, 99) < 15)
				send_cmd(rand_cmd(2'($urandom_range(0, 3))));
			else
				send_ramp_sequence();
		end
		s_tvalid <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		wait_cycles = 50;
		repeat (wait_cycles) @(posedge clk);

		if (sb.failures == 0 && sb.pending() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ----- filelist.f -----
src/dlrg_pkg.sv
src/dlrg_frac_mac.sv
src/delayed_linear_ramp_generator.sv
tb/sv/tb_delayed_linear_ramp_generator.sv
